/* design/cuckoo_bucket_table_unit_macros.svh */
// ----------------------------------------------------------------------------
// cuckoo bucket table assertion macros
// shared property forms for the bucket table checks
// ----------------------------------------------------------------------------
`ifndef CUCKOO_BUCKET_TABLE_UNIT_MACROS_SVH
`define CUCKOO_BUCKET_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define CBT_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("bucket table check failed");

// next-cycle implication
`define CBT_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("bucket table check failed");

`endif

/* design/cbt_pkg.sv */
// ----------------------------------------------------------------------------
// cbt_pkg
// types and constants of the cuckoo filter bucket table
// ----------------------------------------------------------------------------
package cbt_pkg;

    localparam int NUM_BUCKETS      = 1024;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int FP_WIDTH         = 16;

    localparam int IDX_W    = $clog2(NUM_BUCKETS);
    localparam int SLOT_W   = $clog2(SLOTS_PER_BUCKET);
    localparam int CNT_W    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int BUCKET_W = SLOTS_PER_BUCKET * FP_WIDTH;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_COUNT  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ALT
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [9:0]  bucket_index;
        logic [9:0]  alt_bucket_index;
        logic [15:0] fingerprint;
        logic        allow_evict;
        logic [1:0]  victim_slot;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic        evicted_valid;
        logic [15:0] evicted_fp;
        logic [2:0]  occupied_count;
    } t_out;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [IDX_W-1:0]    addr;
        logic [BUCKET_W-1:0] wdata;
    } t_ram_req;

    typedef struct packed {
        logic                write;
        logic [BUCKET_W-1:0] word;
        logic                hit;
        t_out                res;
    } t_eval;

endpackage

/* design/cbt_bucket_ram.sv */
// ----------------------------------------------------------------------------
// cbt_bucket_ram
// single-port bucket memory, one bucket per word, registered read data
// ----------------------------------------------------------------------------
module cbt_bucket_ram (
    input  logic                         i_clk,
    input  cbt_pkg::t_ram_req            i_req,
    output logic [cbt_pkg::BUCKET_W-1:0] o_rdata
);

    logic [cbt_pkg::BUCKET_W-1:0] r_mem [cbt_pkg::NUM_BUCKETS];
    logic [cbt_pkg::BUCKET_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/cbt_bucket_eval.sv */
// ----------------------------------------------------------------------------
// cbt_bucket_eval
// slot search and update of one bucket word for insert, lookup, delete, count
// ----------------------------------------------------------------------------
module cbt_bucket_eval (
    input  logic [cbt_pkg::BUCKET_W-1:0] i_word,
    input  logic [cbt_pkg::FP_WIDTH-1:0] i_mask,
    input  cbt_pkg::t_in                 i_item,
    output cbt_pkg::t_eval               o_eval
);

    logic [cbt_pkg::FP_WIDTH-1:0] slot_val [cbt_pkg::SLOTS_PER_BUCKET];
    logic [cbt_pkg::FP_WIDTH-1:0] fp_masked;
    logic [cbt_pkg::SLOT_W-1:0]   victim;
    logic                         zero_found;
    logic                         match_found;
    logic [cbt_pkg::SLOT_W-1:0]   zero_idx;
    logic [cbt_pkg::SLOT_W-1:0]   match_idx;
    logic [cbt_pkg::CNT_W-1:0]    count;

    always_comb begin
        fp_masked   = i_item.fingerprint & i_mask;
        victim      = i_item.victim_slot;
        zero_found  = 1'b0;
        match_found = 1'b0;
        zero_idx    = '0;
        match_idx   = '0;
        count       = '0;
        for (int s = 0; s < cbt_pkg::SLOTS_PER_BUCKET; s++) begin
            slot_val[s] = i_word[s*cbt_pkg::FP_WIDTH +: cbt_pkg::FP_WIDTH] & i_mask;
            if (slot_val[s] == '0 && !zero_found) begin
                zero_found = 1'b1;
                zero_idx   = cbt_pkg::SLOT_W'(s);
            end
            // lookup and delete compare the unmasked fingerprint
            if (slot_val[s] == i_item.fingerprint && !match_found) begin
                match_found = 1'b1;
                match_idx   = cbt_pkg::SLOT_W'(s);
            end
            if (slot_val[s] != '0) begin
                count = count + cbt_pkg::CNT_W'(1);
            end
        end

        o_eval       = '0;
        o_eval.word  = i_word;
        o_eval.hit   = match_found;
        unique case (i_item.func)
            cbt_pkg::FUNC_INSERT: begin
                if (zero_found) begin
                    o_eval.write  = 1'b1;
                    o_eval.res.ok = 1'b1;
                    o_eval.word[zero_idx*cbt_pkg::FP_WIDTH +: cbt_pkg::FP_WIDTH] = fp_masked;
                end else if (i_item.allow_evict) begin
                    o_eval.write             = 1'b1;
                    o_eval.res.evicted_valid = 1'b1;
                    o_eval.res.evicted_fp    = slot_val[victim];
                    o_eval.word[victim*cbt_pkg::FP_WIDTH +: cbt_pkg::FP_WIDTH] = fp_masked;
                end
            end
            cbt_pkg::FUNC_LOOKUP: begin
                o_eval.res.ok = match_found;
            end
            cbt_pkg::FUNC_DELETE: begin
                if (match_found) begin
                    o_eval.write  = 1'b1;
                    o_eval.res.ok = 1'b1;
                    o_eval.word[match_idx*cbt_pkg::FP_WIDTH +: cbt_pkg::FP_WIDTH] = '0;
                end
            end
            cbt_pkg::FUNC_COUNT: begin
                o_eval.res.occupied_count = count;
            end
            default: begin
                o_eval = '0;
            end
        endcase
    end

endmodule

/* design/cuckoo_bucket_table_unit.sv */
// ----------------------------------------------------------------------------
// cuckoo_bucket_table_unit
// bucket store of a cuckoo filter: insert with eviction, lookup, delete, count
// ----------------------------------------------------------------------------
// sequence: insert, delete and count read one bucket and give their result
// beat from ST_EXEC; lookup reads a second bucket and gives it from ST_ALT
// a new item is taken only in ST_IDLE, after the last result is registered,
// which waits for a free output; one memory port does read, then write-back
// reset: a clearing pass zeroes all 1024 buckets with input ready low,
// mask returns to 0xffff, config writes are taken at any time
// ----------------------------------------------------------------------------
`include "cuckoo_bucket_table_unit_macros.svh"

module cuckoo_bucket_table_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cbt_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output cbt_pkg::t_out   o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [15:0]     i_cfg_data
);

    cbt_pkg::t_state                r_state, n_state;
    logic [cbt_pkg::IDX_W-1:0]      r_clr, n_clr;
    cbt_pkg::t_in                   r_item, n_item;
    logic                           r_hit, n_hit;
    logic                           r_out_valid, n_out_valid;
    cbt_pkg::t_out                  r_out, n_out;
    logic [15:0]                    r_mask;

    cbt_pkg::t_ram_req              ram_req;
    logic [cbt_pkg::BUCKET_W-1:0]   ram_rdata;
    cbt_pkg::t_eval                 eval;
    logic                           out_free;

    cbt_bucket_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    cbt_bucket_eval u_eval (
        .i_word (ram_rdata),
        .i_mask (r_mask[cbt_pkg::FP_WIDTH-1:0]),
        .i_item (r_item),
        .o_eval (eval)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbt_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_mask      <= 16'hffff;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_hit  <= n_hit;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_item      = r_item;
        n_hit       = r_hit;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        ram_req     = '0;
        unique case (r_state)
            cbt_pkg::ST_CLEAR: begin
                ram_req.en   = 1'b1;
                ram_req.we   = 1'b1;
                ram_req.addr = r_clr;
                n_clr        = r_clr + cbt_pkg::IDX_W'(1);
                if (r_clr == cbt_pkg::IDX_W'(cbt_pkg::NUM_BUCKETS - 1)) begin
                    n_state = cbt_pkg::ST_IDLE;
                end
            end
            cbt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    ram_req.en   = 1'b1;
                    ram_req.addr = i_in_data.bucket_index[cbt_pkg::IDX_W-1:0];
                    n_item       = i_in_data;
                    n_state      = cbt_pkg::ST_EXEC;
                end
            end
            cbt_pkg::ST_EXEC: begin
                if (r_item.func == cbt_pkg::FUNC_LOOKUP) begin
                    ram_req.en   = 1'b1;
                    ram_req.addr = r_item.alt_bucket_index[cbt_pkg::IDX_W-1:0];
                    n_hit        = eval.hit;
                    n_state      = cbt_pkg::ST_ALT;
                end else if (out_free) begin
                    // write back only when a slot changed
                    ram_req.en    = eval.write;
                    ram_req.we    = eval.write;
                    ram_req.addr  = r_item.bucket_index[cbt_pkg::IDX_W-1:0];
                    ram_req.wdata = eval.word;
                    n_out         = eval.res;
                    n_out_valid   = 1'b1;
                    n_state       = cbt_pkg::ST_IDLE;
                end
            end
            cbt_pkg::ST_ALT: begin
                if (out_free) begin
                    n_out       = '0;
                    n_out.ok    = r_hit || eval.hit;
                    n_out_valid = 1'b1;
                    n_state     = cbt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cbt_pkg::ST_CLEAR;
            end
        endcase
    end

    `CBT_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == cbt_pkg::ST_EXEC)
    `CBT_ASSERT_IMPL(a_write_state, i_clk, i_rst_n, ram_req.en && ram_req.we,
        r_state == cbt_pkg::ST_CLEAR || r_state == cbt_pkg::ST_EXEC)
    `CBT_ASSERT_IMPL(a_result_src, i_clk, i_rst_n, $rose(o_out_valid),
        $past(r_state) == cbt_pkg::ST_EXEC || $past(r_state) == cbt_pkg::ST_ALT)

endmodule
